/* rtl/alu8_pkg.sv */
// alu8_pkg: shared widths and operation codes for the 8-bit accumulator alu
// used by alu8_with_carry_parity_overflow and its port checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package alu8_pkg;

  localparam int DATA_W = 8;
  localparam int CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_ADC = 3'd1,
    CMD_SUB = 3'd2,
    CMD_SBC = 3'd3,
    CMD_AND = 3'd4,
    CMD_XOR = 3'd5,
    CMD_OR  = 3'd6,
    CMD_CP  = 3'd7
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/alu8_with_carry_parity_overflow.sv */
// alu8_with_carry_parity_overflow: 8-bit accumulator alu with carry and parity/overflow
// input register, one pass of alu logic, result register
// depends on alu8_pkg
//
// usage:
//   input channel: in_valid/in_ready with cmd, operand_a, operand_b, carry_in.
//   output channel: out_valid/out_ready with result, carry_out, parity_overflow.
//   each accepted transaction gives exactly one result transaction, in order.
//   an accepted item goes from the input register through the alu into the
//   result register, from which it is taken on the output.
//   throughput: one transaction per cycle while out_ready stays high; the
//   single-pass alu between the two registers sets this figure.
//   in_ready is high whenever the input register is empty or moving on, so a
//   new transaction is taken while a finished result still waits.
//   stall: with out_ready low a valid result holds in the result register, the input
//   register fills, and then in_ready drops until the output is taken.
//   reset (rst, synchronous, active high) empties both registers by clearing their
//   valid flags; the data is not reset, and no transaction in flight is delivered.
`timescale 1ns / 1ps
`default_nettype none

module alu8_with_carry_parity_overflow (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [alu8_pkg::CMD_W-1:0]  cmd,
  input  wire logic [alu8_pkg::DATA_W-1:0] operand_a,
  input  wire logic [alu8_pkg::DATA_W-1:0] operand_b,
  input  wire logic                        carry_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [alu8_pkg::DATA_W-1:0]      result,
  output logic                             carry_out,
  output logic                             parity_overflow
);

  import alu8_pkg::*;

  logic              in_full;
  cmd_t              cmd_q;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic              cin_q;

  logic              out_load;
  logic [DATA_W:0]   sum_ext;
  logic [DATA_W:0]   diff_ext;
  logic              cin_use;
  logic [DATA_W-1:0] result_next;
  logic              carry_next;
  logic              pv_next;

  assign out_load = !out_valid || out_ready;
  assign in_ready = !in_full || out_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd_q <= cmd_t'(cmd);
      a_q   <= operand_a;
      b_q   <= operand_b;
      cin_q <= carry_in;
    end
  end

  // alu
  always_comb begin
    cin_use  = ((cmd_q == CMD_ADC) || (cmd_q == CMD_SBC)) ? cin_q : 1'b0;
    sum_ext  = {1'b0, a_q} + {1'b0, b_q} + {{DATA_W{1'b0}}, cin_use};
    diff_ext = {1'b0, a_q} - {1'b0, b_q} - {{DATA_W{1'b0}}, cin_use};
    result_next = '0;
    carry_next  = 1'b0;
    pv_next     = 1'b0;
    case (cmd_q)
      CMD_ADD, CMD_ADC: begin
        result_next = sum_ext[DATA_W-1:0];
        carry_next  = sum_ext[DATA_W];
        pv_next     = (a_q[DATA_W-1] ^ sum_ext[DATA_W-1])
                    & (b_q[DATA_W-1] ^ sum_ext[DATA_W-1]);
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        result_next = diff_ext[DATA_W-1:0];
        carry_next  = diff_ext[DATA_W];
        pv_next     = (a_q[DATA_W-1] ^ b_q[DATA_W-1])
                    & (a_q[DATA_W-1] ^ diff_ext[DATA_W-1]);
      end
      CMD_AND: begin
        result_next = a_q & b_q;
        pv_next     = ~^(a_q & b_q);
      end
      CMD_XOR: begin
        result_next = a_q ^ b_q;
        pv_next     = ~^(a_q ^ b_q);
      end
      CMD_OR: begin
        result_next = a_q | b_q;
        pv_next     = ~^(a_q | b_q);
      end
      default: begin
        result_next = '0;
        carry_next  = 1'b0;
        pv_next     = 1'b0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_full;
    end
    if (out_load && in_full) begin
      result          <= result_next;
      carry_out       <= carry_next;
      parity_overflow <= pv_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/alu8_chk.sv */
// alu8_chk: port-level checks for alu8_with_carry_parity_overflow
// bound to the top level below; depends on alu8_pkg
`timescale 1ns / 1ps
`default_nettype none

module alu8_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [alu8_pkg::DATA_W-1:0] result,
  input wire logic                        carry_out,
  input wire logic                        parity_overflow
);

  import alu8_pkg::*;

  logic [DATA_W+1:0] out_word;

  assign out_word = {result, carry_out, parity_overflow};

  // nothing delivered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result changed or dropped");

  // a free output never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // with no result pending the input register has room
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

endmodule

bind alu8_with_carry_parity_overflow alu8_chk u_alu8_chk (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .result          (result),
  .carry_out       (carry_out),
  .parity_overflow (parity_overflow)
);

`default_nettype wire

/* tb/sv/tb.sv */
// tb: self-checking testbench for alu8_with_carry_parity_overflow
// drives operations over valid/ready, predicts result and flags, checks every result transaction
// depends on alu8_pkg and alu8_with_carry_parity_overflow
`timescale 1ns / 1ps

module tb;
  import alu8_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int WDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              co;
    logic              pv;
  } alu_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  cmd_t              cmd;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;
  logic              carry_in;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] result;
  logic              carry_out;
  logic              parity_overflow;

  alu_result_t pending_results[$];
  int          mismatches;
  int          quiet_cycles;
  bit          idle_en;
  bit          stall_en;
  bit          hold_req;

  alu8_with_carry_parity_overflow dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .operand_a       (operand_a),
    .operand_b       (operand_b),
    .carry_in        (carry_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result          (result),
    .carry_out       (carry_out),
    .parity_overflow (parity_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alu_result_t compute_alu(cmd_t c, logic [DATA_W-1:0] a,
                                              logic [DATA_W-1:0] b, logic ci);
    alu_result_t r;
    logic [DATA_W:0] wide;
    logic            cin_used;
    cin_used = (c == CMD_ADC || c == CMD_SBC) ? ci : 1'b0;
    r = '0;
    case (c)
      CMD_ADD, CMD_ADC: begin
        wide = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin_used};
        r.res = wide[DATA_W-1:0];
        r.co = wide[DATA_W];
        r.pv = (a[DATA_W-1] == b[DATA_W-1]) && (r.res[DATA_W-1] != a[DATA_W-1]);
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        // bit 8 of the 9-bit difference is the borrow
        wide = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, cin_used};
        r.res = wide[DATA_W-1:0];
        r.co = wide[DATA_W];
        r.pv = (a[DATA_W-1] != b[DATA_W-1]) && (r.res[DATA_W-1] != a[DATA_W-1]);
      end
      default: begin
        case (c)
          CMD_AND: r.res = a & b;
          CMD_XOR: r.res = a ^ b;
          default: r.res = a | b;
        endcase
        r.co = 1'b0;
        r.pv = ~^r.res;
      end
    endcase
    return r;
  endfunction

  // predict on input transactions, then check output transactions
  always @(negedge clk) begin
    alu_result_t exp_r;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        if (in_valid && in_ready) begin
          pending_results.push_back(compute_alu(cmd, operand_a, operand_b, carry_in));
        end
        if (out_valid && out_ready) begin
          if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result transaction, expected none, got %02h %0b %0b",
                     $time, result, carry_out, parity_overflow);
          end else begin
            exp_r = pending_results.pop_front();
            if (result !== exp_r.res) begin
              mismatches++;
              $display("%0t: result mismatch, expected %02h, got %02h",
                       $time, exp_r.res, result);
            end
            if (carry_out !== exp_r.co) begin
              mismatches++;
              $display("%0t: carry_out mismatch, expected %0b, got %0b",
                       $time, exp_r.co, carry_out);
            end
            if (parity_overflow !== exp_r.pv) begin
              mismatches++;
              $display("%0t: parity_overflow mismatch, expected %0b, got %0b",
                       $time, exp_r.pv, parity_overflow);
            end
          end
        end
      end
    end
  end

  // output side: random stall bursts and one long hold-off on request
  initial begin
    int burst;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (stall_en && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (burst - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_op(cmd_t c, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b, logic ci);
    bit hit;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    operand_a <= a;
    operand_b <= b;
    carry_in <= ci;
    do begin
      @(negedge clk);
      hit = in_valid && in_ready;
      @(posedge clk);
    end while (!hit);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h7f;
      3: return 8'h80;
      default: return DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      send_op(cmd_t'($urandom_range(0, 7)), pick_byte(), pick_byte(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_directed();
    send_op(CMD_ADD, 8'h00, 8'h00, 1'b1);
    send_op(CMD_ADD, 8'hff, 8'h01, 1'b0);
    send_op(CMD_ADD, 8'h7f, 8'h01, 1'b0);
    send_op(CMD_ADD, 8'h80, 8'h80, 1'b1);
    send_op(CMD_ADD, 8'hff, 8'hff, 1'b0);
    send_op(CMD_ADC, 8'hff, 8'h00, 1'b1);
    send_op(CMD_ADC, 8'h7f, 8'h00, 1'b1);
    send_op(CMD_ADC, 8'hff, 8'hff, 1'b1);
    send_op(CMD_SUB, 8'h00, 8'h01, 1'b1);
    send_op(CMD_SUB, 8'h80, 8'h01, 1'b0);
    send_op(CMD_SUB, 8'h7f, 8'hff, 1'b0);
    send_op(CMD_SBC, 8'h00, 8'h00, 1'b1);
    send_op(CMD_SBC, 8'hff, 8'hff, 1'b1);
    send_op(CMD_SBC, 8'h05, 8'h04, 1'b1);
    send_op(CMD_SBC, 8'h80, 8'h00, 1'b1);
    send_op(CMD_AND, 8'hff, 8'hff, 1'b1);
    send_op(CMD_AND, 8'h00, 8'hff, 1'b0);
    send_op(CMD_XOR, 8'haa, 8'h55, 1'b1);
    send_op(CMD_XOR, 8'hff, 8'hff, 1'b0);
    send_op(CMD_OR, 8'h01, 8'h00, 1'b1);
    send_op(CMD_OR, 8'h80, 8'h7f, 1'b0);
    send_op(CMD_CP, 8'h10, 8'h20, 1'b1);
    send_op(CMD_CP, 8'h80, 8'h7f, 1'b0);
    send_op(CMD_CP, 8'h42, 8'h42, 1'b1);
  endtask

  task automatic test_random_traffic();
    idle_en = 1'b1;
    stall_en = 1'b1;
    send_random(1200);
  endtask

  task automatic test_output_hold();
    idle_en = 1'b0;
    stall_en = 1'b0;
    hold_req = 1'b1;
    send_random(40);
    wait_drain();
  endtask

  task automatic test_sender_pause();
    idle_en = 1'b1;
    stall_en = 1'b1;
    repeat (8) begin
      send_random($urandom_range(10, 40));
      wait_drain();
    end
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    stall_en = 1'b0;
    send_random(250);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_ADD;
    operand_a = '0;
    operand_b = '0;
    carry_in = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    idle_en = 1'b0;
    stall_en = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_output_hold();
    test_sender_pause();
    test_full_rate();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/alu8_pkg.sv
rtl/alu8_with_carry_parity_overflow.sv
rtl/alu8_chk.sv
tb/sv/tb.sv
